[rtl/pmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and constants of the perfect matching counter
// Holds the field widths, the microcode format, the control program and the
// structs that pass between the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // Field widths of the transactions
  localparam int VTX_W   = 4;   // vertex index field
  localparam int VCNT_W  = 4;   // vertex_count register
  localparam int COUNT_W = 10;  // pairing_count result

  // Microprogram addressing
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_CLEAR = 3'd0;
  localparam logic [STEP_W-1:0] ST_FIRST = 3'd1;
  localparam logic [STEP_W-1:0] ST_SCAN  = 3'd2;
  localparam logic [STEP_W-1:0] ST_NEXT  = 3'd3;
  localparam logic [STEP_W-1:0] ST_POP   = 3'd4;
  localparam logic [STEP_W-1:0] ST_DONE  = 3'd5;
  localparam logic [STEP_W-1:0] ST_ONE   = 3'd6;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_CLEAR,  // clear taken mask, count and stack depth
    OP_FIRST,  // pick the lowest free vertex as first of a pair
    OP_SCAN,   // find a partner and push the pair
    OP_NEXT,   // pick the next first vertex, or count a full pairing
    OP_POP,    // undo the top pair and resume its scan
    OP_ONE,    // empty graph: one pairing
    OP_DONE    // deliver the count and wipe the adjacency store
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NONE_FREE,
    COND_ANY_FREE,
    COND_NO_PUSH,
    COND_NOT_EMPTY
  } cond_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // One control word of the program
  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic en;
    op_e  op;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic none_free;
    logic can_push;
    logic stack_empty;
  } status_t;

  // Top level to datapath: adjacency write of one edge
  typedef struct packed {
    logic             we;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
  } edge_wr_t;

  // Control store: jump to target when the condition holds, else fall through
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      ST_CLEAR: w = '{op: OP_CLEAR, cond: COND_NEVER,     target: ST_FIRST};
      ST_FIRST: w = '{op: OP_FIRST, cond: COND_NONE_FREE, target: ST_ONE};
      ST_SCAN:  w = '{op: OP_SCAN,  cond: COND_NO_PUSH,   target: ST_POP};
      ST_NEXT:  w = '{op: OP_NEXT,  cond: COND_ANY_FREE,  target: ST_SCAN};
      ST_POP:   w = '{op: OP_POP,   cond: COND_NOT_EMPTY, target: ST_SCAN};
      ST_DONE:  w = '{op: OP_DONE,  cond: COND_NEVER,     target: ST_CLEAR};
      ST_ONE:   w = '{op: OP_ONE,   cond: COND_ALWAYS,    target: ST_DONE};
      default:  w = '{op: OP_DONE,  cond: COND_NEVER,     target: ST_CLEAR};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[rtl/pmc_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmc_chan_if: valid/ready channels of the perfect matching counter
// One interface for the command transactions and one for the results.
// ----------------------------------------------------------------------------
interface pmc_in_if;
  import pmc_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;

  modport source (output valid, mode, vertex_a, vertex_b, input ready);
  modport sink   (input valid, mode, vertex_a, vertex_b, output ready);
endinterface

interface pmc_out_if;
  import pmc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] pairing_count;

  modport source (output valid, pairing_count, input ready);
  modport sink   (input valid, pairing_count, output ready);
endinterface
`default_nettype wire

[rtl/perfect_matching_counter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Edge transaction: accepted while the search is idle, gives no result.
// Count transaction: the backtracking search runs one control word a cycle, and the
//   result is registered on its final step; the final step holds while the output
//   register is still full.
// No new transaction, edge or count, is accepted until the result is loaded.
// Reset (rst_n low, synchronous) clears the adjacency store, count, state and valid flags.
// ----------------------------------------------------------------------------
// perfect_matching_counter: counts perfect matchings of a loaded graph
// Loads an undirected graph one edge per transaction, then on a count
// transaction runs a microcoded backtracking search, emits the number of
// perfect matchings and wipes the graph.
// ----------------------------------------------------------------------------
module perfect_matching_counter import pmc_pkg::*; #(
  parameter int MAX_VERTICES = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pmc_in_if.sink                 in_ch,
  pmc_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [VCNT_W-1:0] cfg_wdata
);

  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [VCNT_W-1:0]  vcount_r;
  logic [NW-1:0]      n_eff;
  logic               busy, accept, start, out_free;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [COUNT_W-1:0] count;
  ctrl_t              ctrl;
  status_t            status;
  edge_wr_t           edge_wr;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  // Saturate the vertex count at capacity
  always_comb begin
    if (32'(vcount_r) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vcount_r);
    end
  end

  // Accept transactions while the search is idle
  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = accept && in_ch.mode;

  // Drop edges that name a vertex outside the graph
  assign edge_wr.we = accept && !in_ch.mode &&
                      (32'(in_ch.vertex_a) < 32'(n_eff)) &&
                      (32'(in_ch.vertex_b) < 32'(n_eff));
  assign edge_wr.a  = in_ch.vertex_a;
  assign edge_wr.b  = in_ch.vertex_b;

  pmc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  pmc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .n       (n_eff),
    .ctrl    (ctrl),
    .edge_wr (edge_wr),
    .status  (status),
    .count   (count)
  );

  // Output register: load on the final step, hold until taken
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.en && ctrl.op == OP_DONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en && ctrl.op == OP_DONE) begin
      out_count_r <= count;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pairing_count = out_count_r;

endmodule
`default_nettype wire

[rtl/pmc_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmc_sequencer: microcode sequencer of the matching search
// Steps through the control store one word a cycle, taking conditional
// jumps on the datapath status, and holds on the final step until the
// result register is free.
// ----------------------------------------------------------------------------
module pmc_sequencer import pmc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    out_free,
  input  wire status_t status,
  output ctrl_t        ctrl,
  output logic         busy
);

  seq_state_e        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  ucode_t            word;
  logic              jump;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      step_r  <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Fetch the control word and resolve its jump
  always_comb begin
    word = ucode_rom(step_r);
    unique case (word.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NONE_FREE: jump = status.none_free;
      COND_ANY_FREE:  jump = !status.none_free;
      COND_NO_PUSH:   jump = !status.can_push;
      COND_NOT_EMPTY: jump = !status.stack_empty;
      default:        jump = 1'b0;
    endcase
  end

  // Advance, branch or hold
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctrl.en   = 1'b0;
    ctrl.op   = word.op;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
          step_nxt  = ST_CLEAR;
        end
      end
      SEQ_RUN: begin
        if (word.op == OP_DONE) begin
          if (out_free) begin
            ctrl.en   = 1'b1;
            state_nxt = SEQ_IDLE;
          end
        end else begin
          ctrl.en  = 1'b1;
          step_nxt = jump ? word.target : step_r + STEP_W'(1);
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  assign busy = (state_r == SEQ_RUN);

endmodule
`default_nettype wire

[rtl/pmc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmc_datapath: adjacency store and backtracking registers
// Holds the adjacency matrix, the taken mask, the pair stack, the current
// first vertex and scan start, and the running count; carries out the
// operation named by the sequencer in each cycle that ctrl.en is set.
// ----------------------------------------------------------------------------
module pmc_datapath import pmc_pkg::*; #(
  parameter int MAX_VERTICES = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0] n,
  input  wire ctrl_t                             ctrl,
  input  wire edge_wr_t                          edge_wr,
  output status_t                                status,
  output logic [COUNT_W-1:0]                     count
);

  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SD  = MAX_VERTICES / 2;
  localparam int DW  = $clog2(SD + 1);
  localparam int SIW = (SD > 1) ? $clog2(SD) : 1;
  localparam logic [MAX_VERTICES-1:0] ONE_BIT = MAX_VERTICES'(1);

  logic [MAX_VERTICES-1:0] adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] taken_r;
  logic [NW-1:0]           f_r, p_r;
  logic [DW-1:0]           depth_r;
  logic [NW-1:0]           stk_f_r [SD];
  logic [NW-1:0]           stk_p_r [SD];
  logic [COUNT_W-1:0]      count_r;

  logic [MAX_VERTICES-1:0] row;
  logic [NW-1:0]           lf, cand;
  logic                    lf_found, cand_found;
  logic [DW-1:0]           depth_m1;
  logic [SIW-1:0]          top_idx, push_idx;
  logic [NW-1:0]           top_f, top_p;

  // Neighbour row of the current first vertex
  always_comb begin
    row = '0;
    if (32'(f_r) < MAX_VERTICES) begin
      row = adj_r[f_r[AW-1:0]];
    end
  end

  // Lowest free vertex below n
  always_comb begin
    lf       = n;
    lf_found = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (!lf_found && i < int'(n) && !taken_r[i]) begin
        lf       = NW'(i);
        lf_found = 1'b1;
      end
    end
  end

  // First free neighbour at or above the scan start
  always_comb begin
    cand       = n;
    cand_found = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (!cand_found && i >= int'(p_r) && i < int'(n) && !taken_r[i] && row[i]) begin
        cand       = NW'(i);
        cand_found = 1'b1;
      end
    end
  end

  // Stack pointers
  assign depth_m1 = depth_r - DW'(1);
  assign top_idx  = depth_m1[SIW-1:0];
  assign push_idx = depth_r[SIW-1:0];
  assign top_f    = stk_f_r[top_idx];
  assign top_p    = stk_p_r[top_idx];

  assign status.none_free   = !lf_found;
  assign status.can_push    = cand_found && (int'(depth_r) < SD);
  assign status.stack_empty = (depth_r == '0);
  assign count              = count_r;

  // Store edges and execute the sequencer operations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adj_r[r] <= '0;
      end
      taken_r <= '0;
      depth_r <= '0;
      count_r <= '0;
    end else begin
      if (edge_wr.we) begin
        adj_r[edge_wr.a[AW-1:0]][edge_wr.b[AW-1:0]] <= 1'b1;
        adj_r[edge_wr.b[AW-1:0]][edge_wr.a[AW-1:0]] <= 1'b1;
      end
      if (ctrl.en) begin
        unique case (ctrl.op)
          OP_CLEAR: begin
            taken_r <= '0;
            depth_r <= '0;
            count_r <= '0;
          end
          OP_FIRST: begin
            f_r <= lf;
            p_r <= lf + NW'(1);
          end
          OP_SCAN: begin
            if (status.can_push) begin
              taken_r           <= taken_r | (ONE_BIT << f_r) | (ONE_BIT << cand);
              stk_f_r[push_idx] <= f_r;
              stk_p_r[push_idx] <= cand;
              depth_r           <= depth_r + DW'(1);
            end
          end
          OP_NEXT: begin
            if (!lf_found) begin
              if (count_r != '1) begin
                count_r <= count_r + COUNT_W'(1);
              end
            end else begin
              f_r <= lf;
              p_r <= lf + NW'(1);
            end
          end
          OP_POP: begin
            if (depth_r != '0) begin
              depth_r <= depth_m1;
              f_r     <= top_f;
              p_r     <= top_p + NW'(1);
              taken_r <= taken_r & ~((ONE_BIT << top_f) | (ONE_BIT << top_p));
            end
          end
          OP_ONE: begin
            count_r <= COUNT_W'(1);
          end
          OP_DONE: begin
            taken_r <= '0;
            for (int r = 0; r < MAX_VERTICES; r++) begin
              adj_r[r] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[rtl/pmc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmc_checker: port-level checks of the perfect matching counter
// Watches the command and result channels and flags handshake and
// sequencing slips; bound to the top level below.
// ----------------------------------------------------------------------------
module pmc_checker import pmc_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_mode,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [COUNT_W-1:0] out_count
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count))
    else $error("result changed or dropped while stalled");

  // Stop accepting once a count transaction starts the search
  a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("transaction accepted during the search");

  // An edge transaction never produces a result
  a_edge_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode && !out_valid |=> !out_valid)
    else $error("result raised after an edge transaction");

  // A result only appears at the end of a search
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while no search was running");

endmodule

bind perfect_matching_counter pmc_checker u_pmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.pairing_count)
);
`default_nettype wire
